FILE: src/irfc_pkg.sv
package irfc_pkg;

    // fixed field widths
    localparam int DIM_W   = 9;
    localparam int COORD_W = 8;
    localparam int PIX_W   = 32;
    localparam int CFG_IW  = 2;
    localparam int CFG_DW  = 9;
    localparam int STORE_W = 10;

    // default image limit
    localparam int MAX_DIM_DEFAULT = 256;

    // item modes
    localparam logic [2:0] MODE_WRITE  = 3'd0;
    localparam logic [2:0] MODE_READ   = 3'd1;
    localparam logic [2:0] MODE_ROT_R  = 3'd2;
    localparam logic [2:0] MODE_ROT_L  = 3'd3;
    localparam logic [2:0] MODE_FLIP_V = 3'd4;
    localparam logic [2:0] MODE_FLIP_H = 3'd5;
    localparam logic [2:0] MODE_CROP   = 3'd6;

    // configuration register indexes
    localparam logic [CFG_IW-1:0] REG_HEIGHT = 2'd0;
    localparam logic [CFG_IW-1:0] REG_WIDTH  = 2'd1;

    // orientation bits
    localparam int ORI_T  = 2;
    localparam int ORI_FR = 1;
    localparam int ORI_FC = 0;

    typedef struct packed {
        logic [2:0]               mode;
        logic [COORD_W-1:0]       pixel_row;
        logic [COORD_W-1:0]       pixel_col;
        logic signed [PIX_W-1:0]  pixel_in;
        logic [COORD_W-1:0]       turns;
        logic [COORD_W-1:0]       crop_left;
        logic [COORD_W-1:0]       crop_right;
        logic [COORD_W-1:0]       crop_top;
        logic [COORD_W-1:0]       crop_bottom;
    } cmd_item_t;

    typedef struct packed {
        logic signed [PIX_W-1:0]  pixel_out;
        logic [DIM_W-1:0]         view_rows;
        logic [DIM_W-1:0]         view_cols;
        logic                     status;
    } res_item_t;

    typedef struct packed {
        logic [2:0]       ori;
        logic [DIM_W-1:0] h;
        logic [DIM_W-1:0] w;
    } view_t;

    typedef struct packed {
        logic [STORE_W-1:0] r;
        logic [STORE_W-1:0] c;
    } coord_t;

    // swap height and width and toggle the transpose bit
    function automatic view_t transpose_view(input view_t v);
        view_t o;
        o = v;
        o.ori[ORI_T] = ~v.ori[ORI_T];
        o.h = v.w;
        o.w = v.h;
        return o;
    endfunction

    // flip of the view rows in stored terms
    function automatic view_t flip_rows(input view_t v);
        view_t o;
        o = v;
        if (v.ori[ORI_T])
        begin
            o.ori[ORI_FC] = ~v.ori[ORI_FC];
        end
        else
        begin
            o.ori[ORI_FR] = ~v.ori[ORI_FR];
        end
        return o;
    endfunction

    // flip of the view columns in stored terms
    function automatic view_t flip_cols(input view_t v);
        view_t o;
        o = v;
        if (v.ori[ORI_T])
        begin
            o.ori[ORI_FR] = ~v.ori[ORI_FR];
        end
        else
        begin
            o.ori[ORI_FC] = ~v.ori[ORI_FC];
        end
        return o;
    endfunction

    // up to three quarter turns, clockwise or anticlockwise
    function automatic view_t rotate_view(input view_t v, input logic [1:0] turns,
                                          input logic clockwise);
        view_t o;
        o = v;
        for (int i = 0; i < 3; i++)
        begin
            if (i < int'(turns))
            begin
                o = clockwise ? flip_rows(o) : flip_cols(o);
                o = transpose_view(o);
            end
        end
        return o;
    endfunction

    // view coordinate to stored coordinate
    function automatic coord_t map_view(input view_t v,
                                        input logic [COORD_W-1:0] roff,
                                        input logic [COORD_W-1:0] coff,
                                        input logic [COORD_W-1:0] r,
                                        input logic [COORD_W-1:0] c);
        coord_t           o;
        logic [DIM_W-1:0] ph;
        logic [DIM_W-1:0] pw;
        logic [DIM_W-1:0] u;
        logic [DIM_W-1:0] x;
        ph = v.ori[ORI_T] ? v.w : v.h;
        pw = v.ori[ORI_T] ? v.h : v.w;
        u  = {1'b0, (v.ori[ORI_T] ? c : r)};
        x  = {1'b0, (v.ori[ORI_T] ? r : c)};
        if (v.ori[ORI_FR])
        begin
            u = ph - 9'd1 - u;
        end
        if (v.ori[ORI_FC])
        begin
            x = pw - 9'd1 - x;
        end
        o.r = {2'b00, roff} + {1'b0, u};
        o.c = {2'b00, coff} + {1'b0, x};
        return o;
    endfunction

endpackage

FILE: src/image_rotate_flip_crop_engine.sv
// Image rotate, flip and crop engine.
// Command channel (cmd_valid, cmd_stall, cmd) carries one item: a pixel write or
// read through the current view, a rotation, a flip or a crop. A command transfer
// takes place when cmd_valid is high and cmd_stall is low.
// Result channel (res_valid, res_stall, res) returns one result per command:
// the pixel read (zero for other modes), the view size after the item and status.
// res_valid rises in the cycle after a command transfer. Throughput is one item
// per cycle without stalls: view changes only update the orientation and window
// registers, and a read or write is a single access of the single-port pixel
// memory. When the receiver stalls, the result register holds and cmd_stall is
// raised until the waiting result is taken in the same cycle as the next command.
// Configuration writes (cfg_valid, cfg_ready, cfg_index, cfg_data) set the image
// height or width, clamped to 1..MAX_DIM, and reset the view to the full image.
// Reset clears the view to identity at the default size and empties the result
// register; the pixel memory keeps no reset value and must be written first.
module image_rotate_flip_crop_engine #(
    parameter int MAX_DIM = irfc_pkg::MAX_DIM_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cmd_valid,
    output logic                         cmd_stall,
    input  irfc_pkg::cmd_item_t          cmd,
    output logic                         res_valid,
    input  logic                         res_stall,
    output irfc_pkg::res_item_t          res,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [irfc_pkg::CFG_IW-1:0]  cfg_index,
    input  logic [irfc_pkg::CFG_DW-1:0]  cfg_data
);
    import irfc_pkg::*;

    localparam int MEM_DEPTH = MAX_DIM * MAX_DIM;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);
    localparam logic [DIM_W-1:0] DIM_RESET =
        DIM_W'((MAX_DIM < 256) ? MAX_DIM : 256);

    // view state
    view_t              view_reg,  view_next;
    logic [COORD_W-1:0] roff_reg,  roff_next;
    logic [COORD_W-1:0] coff_reg,  coff_next;
    logic [DIM_W-1:0]   img_h_reg, img_h_next;
    logic [DIM_W-1:0]   img_w_reg, img_w_next;

    // result stage
    logic               res_valid_reg;
    logic               res_read_reg;
    logic               res_status_reg;
    logic [DIM_W-1:0]   res_rows_reg;
    logic [DIM_W-1:0]   res_cols_reg;
    logic [PIX_W-1:0]   rd_data_reg;

    logic               cmd_xfer;
    logic               cfg_xfer;
    logic               status;
    logic               mem_we;
    logic               mem_re;
    logic [ADDR_W-1:0]  mem_addr;
    coord_t             pos;
    coord_t             crop_a;
    coord_t             crop_b;
    logic [DIM_W-1:0]   cfg_clamped;

    logic [PIX_W-1:0]   mem [MEM_DEPTH];

    assign cmd_stall = res_valid_reg && res_stall;
    assign cmd_xfer  = cmd_valid && !cmd_stall;
    assign cfg_ready = 1'b1;
    assign cfg_xfer  = cfg_valid && cfg_ready;

    // register value limited to 1..MAX_DIM
    always_comb
    begin
        if (cfg_data == '0)
        begin
            cfg_clamped = DIM_W'(1);
        end
        else if (int'(cfg_data) > MAX_DIM)
        begin
            cfg_clamped = DIM_W'(MAX_DIM);
        end
        else
        begin
            cfg_clamped = cfg_data;
        end
    end

    // stored positions for the pixel access and the crop corners
    assign pos    = map_view(view_reg, roff_reg, coff_reg, cmd.pixel_row, cmd.pixel_col);
    assign crop_a = map_view(view_reg, roff_reg, coff_reg, cmd.crop_top, cmd.crop_left);
    assign crop_b = map_view(view_reg, roff_reg, coff_reg, cmd.crop_bottom, cmd.crop_right);

    // item decode and next view
    always_comb
    begin
        view_next  = view_reg;
        roff_next  = roff_reg;
        coff_next  = coff_reg;
        img_h_next = img_h_reg;
        img_w_next = img_w_reg;
        status     = 1'b0;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        mem_addr   = ADDR_W'(int'(pos.r) * MAX_DIM + int'(pos.c));
        if (cmd_xfer)
        begin
            case (cmd.mode) inside
                MODE_WRITE, MODE_READ:
                begin
                    if ({1'b0, cmd.pixel_row} >= view_reg.h ||
                        {1'b0, cmd.pixel_col} >= view_reg.w ||
                        int'(pos.r) >= MAX_DIM || int'(pos.c) >= MAX_DIM)
                    begin
                        status = 1'b1;
                    end
                    else if (cmd.mode == MODE_WRITE)
                    begin
                        mem_we = 1'b1;
                    end
                    else
                    begin
                        mem_re = 1'b1;
                    end
                end
                MODE_ROT_R:
                begin
                    view_next = rotate_view(view_reg, cmd.turns[1:0], 1'b1);
                end
                MODE_ROT_L:
                begin
                    view_next = rotate_view(view_reg, cmd.turns[1:0], 1'b0);
                end
                MODE_FLIP_V:
                begin
                    view_next = flip_rows(view_reg);
                end
                MODE_FLIP_H:
                begin
                    view_next = flip_cols(view_reg);
                end
                MODE_CROP:
                begin
                    if (cmd.crop_left > cmd.crop_right || cmd.crop_top > cmd.crop_bottom ||
                        {1'b0, cmd.crop_right} >= view_reg.w ||
                        {1'b0, cmd.crop_bottom} >= view_reg.h)
                    begin
                        status = 1'b1;
                    end
                    else
                    begin
                        roff_next   = COORD_W'((crop_a.r < crop_b.r) ? crop_a.r : crop_b.r);
                        coff_next   = COORD_W'((crop_a.c < crop_b.c) ? crop_a.c : crop_b.c);
                        view_next.h = {1'b0, cmd.crop_bottom} - {1'b0, cmd.crop_top} + 9'd1;
                        view_next.w = {1'b0, cmd.crop_right} - {1'b0, cmd.crop_left} + 9'd1;
                    end
                end
                default:
                begin
                end
            endcase
        end

        // register write resets the view to the full image
        if (cfg_xfer && (cfg_index == REG_HEIGHT || cfg_index == REG_WIDTH))
        begin
            if (cfg_index == REG_HEIGHT)
            begin
                img_h_next = cfg_clamped;
            end
            else
            begin
                img_w_next = cfg_clamped;
            end
            view_next.ori = '0;
            view_next.h   = (cfg_index == REG_HEIGHT) ? cfg_clamped : img_h_reg;
            view_next.w   = (cfg_index == REG_WIDTH) ? cfg_clamped : img_w_reg;
            roff_next     = '0;
            coff_next     = '0;
        end
    end

    // view and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            view_reg.ori   <= '0;
            view_reg.h     <= DIM_RESET;
            view_reg.w     <= DIM_RESET;
            roff_reg       <= '0;
            coff_reg       <= '0;
            img_h_reg      <= DIM_RESET;
            img_w_reg      <= DIM_RESET;
            res_valid_reg  <= 1'b0;
            res_read_reg   <= 1'b0;
            res_status_reg <= 1'b0;
            res_rows_reg   <= DIM_RESET;
            res_cols_reg   <= DIM_RESET;
        end
        else
        begin
            view_reg  <= view_next;
            roff_reg  <= roff_next;
            coff_reg  <= coff_next;
            img_h_reg <= img_h_next;
            img_w_reg <= img_w_next;
            if (cmd_xfer)
            begin
                res_valid_reg  <= 1'b1;
                res_read_reg   <= mem_re;
                res_status_reg <= status;
                res_rows_reg   <= view_next.h;
                res_cols_reg   <= view_next.w;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // pixel memory, single port with registered read data
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= cmd.pixel_in;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_addr];
        end
    end

    // result payload
    assign res_valid     = res_valid_reg;
    assign res.pixel_out = res_read_reg ? rd_data_reg : '0;
    assign res.view_rows = res_rows_reg;
    assign res.view_cols = res_cols_reg;
    assign res.status    = res_status_reg;

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    import irfc_pkg::*;

    localparam int          IMG_MAX     = MAX_DIM_DEFAULT;
    localparam int unsigned QUIET_LIMIT = 400;
    localparam int unsigned RANDOM_CMDS = 400;
    localparam int unsigned NO_ADDR     = 32'hFFFF_FFFF;
    localparam logic [2:0]  MODE_SPARE  = 3'd7;
    localparam logic [CFG_IW-1:0] REG_SPARE = 2'd3;

    typedef struct packed {
        logic [31:0] r;
        logic [31:0] c;
    } spot_t;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              cmd_valid = 1'b0;
    logic              cmd_stall;
    cmd_item_t         cmd       = '0;
    logic              res_valid;
    logic              res_stall = 1'b0;
    res_item_t         res;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [CFG_IW-1:0] cfg_index = '0;
    logic [CFG_DW-1:0] cfg_data  = '0;

    // commands waiting for the driver and results predicted for them
    cmd_item_t queued_cmds[$];
    res_item_t predicted_res[$];

    int unsigned cmds_issued   = 0;
    int unsigned mismatches    = 0;
    int unsigned send_wait     = 0;
    int unsigned hold_left     = 0;
    int unsigned send_idle_max = 5;
    int unsigned recv_idle_max = 5;
    int unsigned quiet_cycles  = 0;

    // shadow of the view mapping and the pixel memory
    logic [2:0]              ori_now   = '0;
    int unsigned             row_base  = 0;
    int unsigned             col_base  = 0;
    int unsigned             rows_now  = IMG_MAX;
    int unsigned             cols_now  = IMG_MAX;
    int unsigned             img_rows  = IMG_MAX;
    int unsigned             img_cols  = IMG_MAX;
    logic signed [PIX_W-1:0] pixel_mem [IMG_MAX*IMG_MAX];
    bit                      pixel_written [IMG_MAX*IMG_MAX];

    image_rotate_flip_crop_engine dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock and reset
    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
    end

    // register values outside 1..max are pulled to the nearest end
    function automatic int unsigned fit_dim(input logic [CFG_DW-1:0] value);
        if (value == '0)
            return 1;
        if (32'(value) > IMG_MAX)
            return IMG_MAX;
        return 32'(value);
    endfunction

    function automatic void restore_full_view();
        ori_now  = '0;
        row_base = 0;
        col_base = 0;
        rows_now = img_rows;
        cols_now = img_cols;
    endfunction

    function automatic void load_dimension(input logic [CFG_IW-1:0] idx,
                                           input logic [CFG_DW-1:0] value);
        if (idx == REG_HEIGHT)
        begin
            img_rows = fit_dim(value);
            restore_full_view();
        end
        else if (idx == REG_WIDTH)
        begin
            img_cols = fit_dim(value);
            restore_full_view();
        end
    endfunction

    // view coordinate to stored coordinate
    function automatic spot_t to_stored(input int unsigned r, input int unsigned c);
        spot_t       s;
        int unsigned span_r;
        int unsigned span_c;
        int unsigned u;
        int unsigned v;
        span_r = ori_now[ORI_T] ? cols_now : rows_now;
        span_c = ori_now[ORI_T] ? rows_now : cols_now;
        u = ori_now[ORI_T] ? c : r;
        v = ori_now[ORI_T] ? r : c;
        if (ori_now[ORI_FR])
            u = span_r - 1 - u;
        if (ori_now[ORI_FC])
            v = span_c - 1 - v;
        s.r = row_base + u;
        s.c = col_base + v;
        return s;
    endfunction

    // memory word behind a view pixel, or none when outside the view
    function automatic int unsigned pixel_addr(input int unsigned r, input int unsigned c);
        spot_t s;
        if (r >= rows_now || c >= cols_now)
            return NO_ADDR;
        s = to_stored(r, c);
        if (s.r >= IMG_MAX || s.c >= IMG_MAX)
            return NO_ADDR;
        return s.r * IMG_MAX + s.c;
    endfunction

    function automatic bit is_blank_read(input int unsigned r, input int unsigned c);
        int unsigned addr;
        addr = pixel_addr(r, c);
        return addr != NO_ADDR && !pixel_written[addr];
    endfunction

    function automatic void mirror_rows();
        if (ori_now[ORI_T])
            ori_now[ORI_FC] = ~ori_now[ORI_FC];
        else
            ori_now[ORI_FR] = ~ori_now[ORI_FR];
    endfunction

    function automatic void mirror_cols();
        if (ori_now[ORI_T])
            ori_now[ORI_FR] = ~ori_now[ORI_FR];
        else
            ori_now[ORI_FC] = ~ori_now[ORI_FC];
    endfunction

    function automatic void swap_axes();
        int unsigned t;
        ori_now[ORI_T] = ~ori_now[ORI_T];
        t        = rows_now;
        rows_now = cols_now;
        cols_now = t;
    endfunction

    // one command through the shadow view, giving its result
    function automatic res_item_t step_view_engine(input cmd_item_t c);
        res_item_t   o;
        int unsigned addr;
        spot_t       a;
        spot_t       b;
        o = '0;
        case (c.mode) inside
            MODE_WRITE, MODE_READ:
            begin
                addr = pixel_addr(32'(c.pixel_row), 32'(c.pixel_col));
                if (addr == NO_ADDR)
                    o.status = 1'b1;
                else if (c.mode == MODE_WRITE)
                begin
                    pixel_mem[addr]     = c.pixel_in;
                    pixel_written[addr] = 1'b1;
                end
                else
                    o.pixel_out = pixel_mem[addr];
            end
            MODE_ROT_R:
            begin
                for (int i = 0; i < int'(c.turns[1:0]); i++)
                begin
                    mirror_rows();
                    swap_axes();
                end
            end
            MODE_ROT_L:
            begin
                for (int i = 0; i < int'(c.turns[1:0]); i++)
                begin
                    mirror_cols();
                    swap_axes();
                end
            end
            MODE_FLIP_V: mirror_rows();
            MODE_FLIP_H: mirror_cols();
            MODE_CROP:
            begin
                if (c.crop_left > c.crop_right || c.crop_top > c.crop_bottom ||
                    32'(c.crop_right) >= cols_now || 32'(c.crop_bottom) >= rows_now)
                    o.status = 1'b1;
                else
                begin
                    a = to_stored(32'(c.crop_top), 32'(c.crop_left));
                    b = to_stored(32'(c.crop_bottom), 32'(c.crop_right));
                    row_base = (a.r < b.r) ? a.r : b.r;
                    col_base = (a.c < b.c) ? a.c : b.c;
                    rows_now = 32'(c.crop_bottom) - 32'(c.crop_top) + 1;
                    cols_now = 32'(c.crop_right) - 32'(c.crop_left) + 1;
                end
            end
            default: ;
        endcase
        o.view_rows = DIM_W'(rows_now);
        o.view_cols = DIM_W'(cols_now);
        return o;
    endfunction

    // command with the given mode and every other field random
    function automatic cmd_item_t blank_command(input logic [2:0] mode);
        cmd_item_t c;
        c.mode        = mode;
        c.pixel_row   = COORD_W'($urandom);
        c.pixel_col   = COORD_W'($urandom);
        c.pixel_in    = PIX_W'($urandom);
        c.turns       = COORD_W'($urandom);
        c.crop_left   = COORD_W'($urandom);
        c.crop_right  = COORD_W'($urandom);
        c.crop_top    = COORD_W'($urandom);
        c.crop_bottom = COORD_W'($urandom);
        return c;
    endfunction

    function automatic cmd_item_t at_pixel(input logic [2:0] mode, input int unsigned r,
                                           input int unsigned c,
                                           input logic signed [PIX_W-1:0] value);
        cmd_item_t o;
        o = blank_command(mode);
        o.pixel_row = COORD_W'(r);
        o.pixel_col = COORD_W'(c);
        o.pixel_in  = value;
        return o;
    endfunction

    function automatic cmd_item_t turn_by(input logic [2:0] mode, input int unsigned turns);
        cmd_item_t o;
        o = blank_command(mode);
        o.turns = COORD_W'(turns);
        return o;
    endfunction

    function automatic cmd_item_t crop_to(input int unsigned l, input int unsigned r,
                                          input int unsigned t, input int unsigned b);
        cmd_item_t o;
        o = blank_command(MODE_CROP);
        o.crop_left   = COORD_W'(l);
        o.crop_right  = COORD_W'(r);
        o.crop_top    = COORD_W'(t);
        o.crop_bottom = COORD_W'(b);
        return o;
    endfunction

    // mostly inside the view, now and then past its edge
    function automatic logic [COORD_W-1:0] pick_coord(input int unsigned span);
        if (span < IMG_MAX && $urandom_range(0, 15) == 0)
            return COORD_W'($urandom_range(span, IMG_MAX - 1));
        return COORD_W'($urandom_range(0, span - 1));
    endfunction

    function automatic cmd_item_t random_command();
        cmd_item_t   c;
        int unsigned pick;
        int unsigned tries;
        pick = $urandom_range(0, 99);
        c    = blank_command(MODE_WRITE);
        if (pick < 30)
        begin
            c.pixel_row = pick_coord(rows_now);
            c.pixel_col = pick_coord(cols_now);
        end
        else if (pick < 62)
        begin
            // look for a pixel that already holds data
            c.mode = MODE_READ;
            tries  = 0;
            do
            begin
                c.pixel_row = pick_coord(rows_now);
                c.pixel_col = pick_coord(cols_now);
                tries++;
            end
            while (tries < 16 && is_blank_read(32'(c.pixel_row), 32'(c.pixel_col)));
        end
        else if (pick < 70)
            c.mode = MODE_ROT_R;
        else if (pick < 78)
            c.mode = MODE_ROT_L;
        else if (pick < 84)
            c.mode = MODE_FLIP_V;
        else if (pick < 90)
            c.mode = MODE_FLIP_H;
        else if (pick < 98)
        begin
            c.mode = MODE_CROP;
            if ($urandom_range(0, 3) != 0)
            begin
                c.crop_left   = COORD_W'($urandom_range(0, cols_now - 1));
                c.crop_right  = COORD_W'($urandom_range(32'(c.crop_left), cols_now - 1));
                c.crop_top    = COORD_W'($urandom_range(0, rows_now - 1));
                c.crop_bottom = COORD_W'($urandom_range(32'(c.crop_top), rows_now - 1));
            end
        end
        else
            c.mode = MODE_SPARE;
        return c;
    endfunction

    // a read of a never written pixel becomes a write
    task automatic queue_command(input cmd_item_t c);
        cmd_item_t item;
        item = c;
        if (item.mode == MODE_READ && is_blank_read(32'(item.pixel_row), 32'(item.pixel_col)))
            item.mode = MODE_WRITE;
        predicted_res.push_back(step_view_engine(item));
        queued_cmds.push_back(item);
        cmds_issued++;
    endtask

    // load the view: every pixel when small, else corners and a scatter
    task automatic fill_view();
        if (rows_now * cols_now <= 64)
        begin
            for (int unsigned r = 0; r < rows_now; r++)
                for (int unsigned c = 0; c < cols_now; c++)
                    queue_command(at_pixel(MODE_WRITE, r, c, PIX_W'($urandom)));
        end
        else
        begin
            for (int k = 0; k < 16; k++)
            begin
                if (k < 4)
                    queue_command(at_pixel(MODE_WRITE, k[1] ? rows_now - 1 : 0,
                                           k[0] ? cols_now - 1 : 0, PIX_W'($urandom)));
                else
                    queue_command(at_pixel(MODE_WRITE, $urandom_range(0, rows_now - 1),
                                           $urandom_range(0, cols_now - 1),
                                           PIX_W'($urandom)));
            end
        end
    endtask

    task automatic wait_idle();
        do
            @(posedge clk);
        while (queued_cmds.size() != 0 || predicted_res.size() != 0 || cmd_valid);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IW-1:0] idx,
                                  input logic [CFG_DW-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        load_dimension(idx, value);
    endtask

    task automatic check_result(input res_item_t got);
        res_item_t want;
        if (predicted_res.size() == 0)
        begin
            $display("%0t: result with nothing expected: pixel %0d rows %0d cols %0d status %0d",
                     $time, got.pixel_out, got.view_rows, got.view_cols, got.status);
            mismatches++;
        end
        else
        begin
            want = predicted_res.pop_front();
            if (got.pixel_out !== want.pixel_out)
            begin
                $display("%0t: pixel_out expected %0d got %0d", $time, want.pixel_out,
                         got.pixel_out);
                mismatches++;
            end
            if (got.view_rows !== want.view_rows)
            begin
                $display("%0t: view_rows expected %0d got %0d", $time, want.view_rows,
                         got.view_rows);
                mismatches++;
            end
            if (got.view_cols !== want.view_cols)
            begin
                $display("%0t: view_cols expected %0d got %0d", $time, want.view_cols,
                         got.view_cols);
                mismatches++;
            end
            if (got.status !== want.status)
            begin
                $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
                mismatches++;
            end
        end
    endtask

    // command driver, with a random gap after each transfer
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid <= 1'b0;
            cmd       <= '0;
            send_wait <= 0;
        end
        else if (!cmd_valid || !cmd_stall)
        begin
            if (send_wait != 0)
            begin
                cmd_valid <= 1'b0;
                send_wait <= send_wait - 1;
            end
            else if (queued_cmds.size() != 0)
            begin
                cmd       <= queued_cmds.pop_front();
                cmd_valid <= 1'b1;
                send_wait <= $urandom_range(0, send_idle_max);
            end
            else
                cmd_valid <= 1'b0;
        end
    end

    // result monitor, with a random stall after each transfer
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_stall <= 1'b0;
            hold_left = 0;
        end
        else
        begin
            if (res_valid && !res_stall)
            begin
                check_result(res);
                hold_left = $urandom_range(0, recv_idle_max);
            end
            else if (hold_left != 0)
                hold_left = hold_left - 1;
            res_stall <= (hold_left != 0);
        end
    end

    // watchdog on cycles with no transfer on any channel
    always @(posedge clk)
    begin
        if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // stimulus
    initial
    begin
        int unsigned phase;
        int unsigned h;
        int unsigned w;
        int unsigned directed_end;
        int unsigned burst;
        wait (rst_n);
        @(posedge clk);

        // corners of the full default image
        queue_command(at_pixel(MODE_WRITE, 0, 0, 32'sh7FFF_FFFF));
        queue_command(at_pixel(MODE_WRITE, 255, 255, 32'sh8000_0000));
        queue_command(at_pixel(MODE_WRITE, 0, 255, -32'sd1));
        queue_command(at_pixel(MODE_WRITE, 255, 0, 32'sd0));
        for (int k = 0; k < 4; k++)
            queue_command(at_pixel(MODE_READ, k[1] ? 255 : 0, k[0] ? 255 : 0, 32'sd0));

        // turns, including zero and counts that wrap
        queue_command(turn_by(MODE_ROT_R, 1));
        queue_command(at_pixel(MODE_READ, 0, 255, 32'sd0));
        queue_command(turn_by(MODE_ROT_L, 255));
        queue_command(at_pixel(MODE_READ, 255, 0, 32'sd0));
        queue_command(turn_by(MODE_ROT_R, 0));
        queue_command(turn_by(MODE_ROT_R, 4));
        queue_command(at_pixel(MODE_READ, 255, 255, 32'sd0));
        queue_command(blank_command(MODE_FLIP_V));
        queue_command(blank_command(MODE_FLIP_H));
        queue_command(at_pixel(MODE_READ, 0, 255, 32'sd0));
        queue_command(blank_command(MODE_SPARE));

        // crop to one row, then coordinates and windows out of range
        queue_command(crop_to(0, 255, 255, 255));
        queue_command(at_pixel(MODE_READ, 0, 0, 32'sd0));
        queue_command(at_pixel(MODE_READ, 0, 255, 32'sd0));
        queue_command(at_pixel(MODE_WRITE, 1, 0, 32'sd5));
        queue_command(at_pixel(MODE_READ, 255, 3, 32'sd0));
        queue_command(crop_to(5, 4, 0, 0));
        queue_command(crop_to(0, 0, 1, 0));
        queue_command(crop_to(0, 0, 0, 1));
        wait_idle();
        write_register(REG_SPARE, CFG_DW'($urandom));

        // random phases, each under a new image size
        directed_end = cmds_issued;
        phase        = 0;
        while (cmds_issued - directed_end < RANDOM_CMDS)
        begin
            case (phase)
                0: begin h = 0;   w = 0;   end
                1: begin h = 511; w = 300; end
                2: begin h = 1;   w = 256; end
                3: begin h = 256; w = 1;   end
                4: begin h = 2;   w = 3;   end
                5: begin h = 257; w = 5;   end
                6: begin h = 7;   w = 7;   end
                7: begin h = 256; w = 256; end
                default:
                begin
                    if ($urandom_range(0, 4) == 0)
                    begin
                        h = $urandom_range(0, 511);
                        w = $urandom_range(0, 511);
                    end
                    else
                    begin
                        h = $urandom_range(1, 12);
                        w = $urandom_range(1, 12);
                    end
                end
            endcase
            if ($urandom_range(0, 1) != 0)
            begin
                write_register(REG_HEIGHT, CFG_DW'(h));
                write_register(REG_WIDTH, CFG_DW'(w));
            end
            else
            begin
                write_register(REG_WIDTH, CFG_DW'(w));
                write_register(REG_HEIGHT, CFG_DW'(h));
            end
            send_idle_max = ($urandom_range(0, 3) == 0) ? 0 : 5;
            recv_idle_max = ($urandom_range(0, 3) == 0) ? 0 : 5;

            fill_view();
            burst = $urandom_range(20, 40);
            for (int unsigned n = 0; n < burst; n++)
                queue_command(random_command());
            wait_idle();
            phase++;
        end

        // drain and report
        do
            @(posedge clk);
        while (predicted_res.size() != 0);
        repeat (5) @(posedge clk);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: image_rotate_flip_crop_engine.f
src/irfc_pkg.sv
src/image_rotate_flip_crop_engine.sv
tb/tb_top.sv
